@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define AST_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AST_IMPL(label, clk, rst_n, ante, cons)
`define AST_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/aes_pkg.sv @@
`timescale 1ns / 1ps
package aes_pkg;
  localparam logic [2:0] OP_MALLOC  = 3'd0;
  localparam logic [2:0] OP_CALLOC  = 3'd1;
  localparam logic [2:0] OP_REALLOC = 3'd2;
  localparam logic [2:0] OP_FREE    = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;
  localparam logic [1:0] REG_ALIGN = 2'd0;
  localparam logic [1:0] REG_OVH   = 2'd1;
  localparam logic [1:0] REG_TPS   = 2'd2;
  localparam logic [9:0] MS_SCALE = 10'd1000;
  localparam logic [5:0] SEL_GLOBAL = 6'd28;
  localparam logic [5:0] SEL_END    = 6'd34;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;
endpackage

@@ rtl/core/aes_div.sv @@
`timescale 1ns / 1ps
module aes_div import aes_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  div_req_t    req,
  output logic        done,
  output logic [63:0] quot,
  output logic [31:0] rem
);
  logic [63:0] q_r, q_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] d_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [32:0] trial;
  logic [32:0] shifted;

  assign shifted = {rem_r, q_r[63]};
  assign trial = shifted - {1'b0, d_r};

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      q_nxt = req.dividend;
      rem_nxt = '0;
      cnt_nxt = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        q_nxt = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = shifted[31:0];
        q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    if (req.start) d_r <= req.divisor;
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem = rem_r;
endmodule

@@ rtl/core/aes_stat_mem.sv @@
`timescale 1ns / 1ps
module aes_stat_mem import aes_pkg::*; (
  input  logic        clk,
  input  logic        we,
  input  logic [4:0]  waddr,
  input  logic [63:0] wdata,
  input  logic [4:0]  raddr,
  output logic [63:0] rdata
);
  logic [63:0] mem [0:27];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/allocation_event_statistics_unit.sv @@
`timescale 1ns / 1ps
// Allocation event statistics unit.
// Input channel in_*: one request per heap event or statistic read.
//   in_tdata holds, from the lowest bit up: op, new_size, old_size,
//   old_present, cost_ticks, interval_ticks, stat_select.
// Output channel out_*: one result per request: stat_value, memory_in_use,
//   objects_in_use, peak_memory, peak_objects, lowest bits first.
// Configuration channel cfg_*: index 0 alignment, 1 overhead, 2 ticks per
// second; the user writes it only while the block is idle; not enforced.
// The per-category counters live in a 28-entry memory with a registered read;
// globals are in flip-flops. After reset the memory is cleared entry by entry,
// during which no request is accepted.
// One request at a time. An event runs three or four 64-step divisions, four
// for a realloc of an existing block, on the shared bit-serial divider
// (milliseconds of cost and interval, padding of the new and old size), then
// squaring and read-modify-write over seven memory entries. A read fetches
// the selected statistic; an ignored opcode goes straight to the output.
// The result waits in the output register while the receiver stalls; the
// next request can be accepted in the cycle after it is delivered.
module allocation_event_statistics_unit import aes_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [143:0] in_tdata,   // op, new_size, old_size, old_present,
                                   // cost_ticks, interval_ticks, stat_select
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [191:0] out_tdata,  // stat_value, memory_in_use,
                                   // objects_in_use, peak_memory, peak_objects
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
`include "assert_macros.svh"
  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_DWT  = 4'd3;
  localparam logic [3:0] S_PREP = 4'd4;
  localparam logic [3:0] S_MRD  = 4'd5;
  localparam logic [3:0] S_MWT  = 4'd6;
  localparam logic [3:0] S_MWR  = 4'd7;
  localparam logic [3:0] S_RRD  = 4'd8;
  localparam logic [3:0] S_RWT  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;
  localparam logic [3:0] S_SQ   = 4'd11;

  logic [3:0]  st_r;
  logic [15:0] align_r, ovh_r;
  logic [31:0] tps_r;
  logic [2:0]  op_r;
  logic [31:0] sz_r, osz_r, cost_r, ival_r;
  logic        ook_r;
  logic [5:0]  sel_r;
  logic [1:0]  dstep_r;
  logic [31:0] cms_r, ims_r, act_r, aold_r, delta_r;
  logic [63:0] dsq_r, csq_r;
  logic [2:0]  fld_r;
  logic [4:0]  clr_r;
  logic [31:0] blive_r, bpeak_r, olive_r, opeak_r, imin_r, imax_r;
  logic [63:0] stat_r;
  logic        ovalid_r;
  logic [31:0] ob_r, oo_r, obp_r, oop_r;

  div_req_t    dreq;
  logic        ddone;
  logic [63:0] dquot;
  logic        we;
  logic [4:0]  waddr, raddr;
  logic [63:0] wdata, rdata;
  logic [1:0]  cat;
  logic [5:0]  cat7;
  logic [31:0] szsel, pad_e, rem32;
  logic [31:0] ms_val;
  logic [63:0] mult_a;
  logic        msq_sel;
  logic [63:0] sq_prod;

  aes_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quot(dquot),
                 .rem(rem32));
  aes_stat_mem u_mem (.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
                      .raddr(raddr), .rdata(rdata));

  assign cat = op_r[1:0];
  assign cat7 = {1'b0, cat, 3'b000} - {4'b0, cat};
  assign in_tready = (st_r == S_IDLE) && !ovalid_r;
  assign cfg_ready = 1'b1;
  assign out_tvalid = ovalid_r;
  assign out_tdata = {oop_r, obp_r, oo_r, ob_r, stat_r};

  // Divider steps: 0 cost ms, 1 interval ms, 2 new size rem, 3 old size rem.
  assign szsel = (dstep_r == 2'd2) ? sz_r : osz_r;
  assign pad_e = szsel - 32'd1;
  always_comb begin
    dreq = '0;
    if (st_r == S_DIV) begin
      dreq.start = 1'b1;
      case (dstep_r)
        2'd0: begin
          dreq.dividend = {32'd0, cost_r} * {54'd0, MS_SCALE};
          dreq.divisor = tps_r;
        end
        2'd1: begin
          dreq.dividend = {32'd0, ival_r} * {54'd0, MS_SCALE};
          dreq.divisor = tps_r;
        end
        default: begin
          dreq.dividend = {32'd0, pad_e};
          dreq.divisor = {16'd0, align_r};
        end
      endcase
    end
  end
  assign ms_val = (tps_r == '0) ? 32'hFFFF_FFFF : dquot[31:0];

  assign msq_sel = fld_r[0];
  assign mult_a = msq_sel ? {32'd0, cost_r} : {32'd0, delta_r};
  assign sq_prod = mult_a * mult_a;

  always_comb begin
    we = 1'b0;
    waddr = clr_r;
    wdata = '0;
    raddr = 5'(cat7) + 5'(fld_r);
    if (st_r == S_CLR) begin
      we = 1'b1;
    end else if (st_r == S_RRD) begin
      raddr = 5'(sel_r);
    end else if (st_r == S_MWR) begin
      we = 1'b1;
      waddr = 5'(cat7) + 5'(fld_r);
      case (fld_r)
        3'd0: wdata = {32'd0, rdata[31:0] + 32'd1};
        3'd1: wdata = {32'd0, rdata[31:0] - aold_r + act_r};
        3'd2: wdata = {32'd0, rdata[31:0] + cms_r};
        3'd3: wdata = rdata + {32'd0, delta_r};
        3'd4: wdata = rdata + dsq_r;
        3'd5: wdata = rdata + {32'd0, cost_r};
        default: wdata = rdata + csq_r;
      endcase
    end
  end

  logic [31:0] nb, no;
  always_comb begin
    nb = blive_r + act_r;
    no = olive_r + 32'd1;
    if (op_r == OP_FREE) begin
      nb = blive_r - act_r;
      no = olive_r - 32'd1;
    end else if (op_r == OP_REALLOC) begin
      nb = blive_r - aold_r + act_r;
      no = ook_r ? olive_r : olive_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      clr_r <= '0;
      ovalid_r <= 1'b0;
      align_r <= 16'd16;
      ovh_r <= 16'd8;
      tps_r <= 32'd1000000;
      blive_r <= '0;
      bpeak_r <= '0;
      olive_r <= '0;
      opeak_r <= '0;
      imin_r <= '1;
      imax_r <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_ALIGN: align_r <= cfg_data[15:0];
          REG_OVH: ovh_r <= cfg_data[15:0];
          REG_TPS: tps_r <= cfg_data;
          default: ;
        endcase
      end
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      case (st_r)
        S_CLR: begin
          clr_r <= clr_r + 5'd1;
          if (clr_r == 5'd27) st_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            op_r <= in_tdata[2:0];
            sz_r <= in_tdata[34:3];
            osz_r <= in_tdata[66:35];
            ook_r <= in_tdata[67];
            cost_r <= in_tdata[99:68];
            ival_r <= in_tdata[131:100];
            sel_r <= in_tdata[137:132];
            stat_r <= '0;
            dstep_r <= '0;
            act_r <= '0;
            aold_r <= '0;
            if (in_tdata[2:0] == OP_READ) begin
              st_r <= S_RRD;
            end else if (in_tdata[2:0] <= OP_FREE) begin
              if (in_tdata[2:0] == OP_REALLOC && in_tdata[34:3] == '0) begin
                op_r <= OP_FREE;
                sz_r <= in_tdata[67] ? in_tdata[66:35] : 32'd0;
                ook_r <= 1'b0;
              end
              st_r <= S_DIV;
            end else begin
              st_r <= S_OUT;
            end
          end
        end
        S_DIV: st_r <= S_DWT;
        S_DWT: begin
          if (ddone) begin
            case (dstep_r)
              2'd0: cms_r <= ms_val;
              2'd1: ims_r <= ms_val;
              2'd2: act_r <= (sz_r == '0) ? 32'd0 : pad_e + {16'd0, ovh_r}
                             + {16'd0, align_r} - ((align_r == '0) ? 32'd0 : rem32);
              default: aold_r <= (osz_r == '0) ? 32'd0 : pad_e + {16'd0, ovh_r}
                             + {16'd0, align_r} - ((align_r == '0) ? 32'd0 : rem32);
            endcase
            if (dstep_r == 2'd3 || (dstep_r == 2'd2 && !(op_r == OP_REALLOC && ook_r)))
              st_r <= S_PREP;
            else begin
              dstep_r <= dstep_r + 2'd1;
              st_r <= S_DIV;
            end
          end
        end
        S_PREP: begin
          delta_r <= (op_r == OP_REALLOC) ?
                     ((act_r > aold_r) ? act_r - aold_r : aold_r - act_r) : act_r;
          fld_r <= 3'd0;
          st_r <= S_SQ;
        end
        S_SQ: begin
          if (fld_r == 3'd0) begin
            dsq_r <= sq_prod;
            fld_r <= 3'd1;
          end else begin
            csq_r <= sq_prod;
            fld_r <= 3'd0;
            st_r <= S_MRD;
          end
        end
        S_MRD: st_r <= S_MWT;
        S_MWT: st_r <= S_MWR;
        S_MWR: begin
          if (fld_r == 3'd6) begin
            blive_r <= nb;
            olive_r <= no;
            if (op_r != OP_FREE) begin
              if (nb > bpeak_r) bpeak_r <= nb;
              if (no > opeak_r) opeak_r <= no;
            end
            if (ims_r < imin_r) imin_r <= ims_r;
            if (ims_r > imax_r) imax_r <= ims_r;
            st_r <= S_OUT;
          end else begin
            fld_r <= fld_r + 3'd1;
            st_r <= S_MRD;
          end
        end
        S_RRD: st_r <= S_RWT;
        S_RWT: begin
          if (sel_r < SEL_GLOBAL) stat_r <= rdata;
          else begin
            case (sel_r - SEL_GLOBAL)
              6'd0: stat_r <= {32'd0, blive_r};
              6'd1: stat_r <= {32'd0, bpeak_r};
              6'd2: stat_r <= {32'd0, olive_r};
              6'd3: stat_r <= {32'd0, opeak_r};
              6'd4: stat_r <= {32'd0, imin_r};
              6'd5: stat_r <= {32'd0, imax_r};
              default: stat_r <= '0;
            endcase
          end
          st_r <= S_OUT;
        end
        S_OUT: begin
          ovalid_r <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_OUT) begin
      ob_r <= blive_r;
      oo_r <= olive_r;
      obp_r <= bpeak_r;
      oop_r <= opeak_r;
    end
  end

  `AST_IMPL(a_no_accept_busy, clk, rst_n, st_r != S_IDLE, !in_tready)
  `AST_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `AST_IMPL(a_we_only_rmw, clk, rst_n, we, st_r == S_CLR || st_r == S_MWR)
endmodule
